[hw/rtl/lai_pkg.sv]
// ============================================================================
// lai_pkg - shared definitions for the leapfrog atom integrator
// Payload types, register map, microcode fields, program table and helpers.
// ============================================================================
package lai_pkg;

   localparam int NUM_SPECIES = 4;
   localparam int STEP_W      = 5;

   localparam logic [62:0] MASK63 = {63{1'b1}};
   localparam logic [23:0] MASK24 = {24{1'b1}};

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   // program entry points
   localparam logic [STEP_W-1:0] STEP_FULL_ENTRY = 5'd0;
   localparam logic [STEP_W-1:0] STEP_POS_JOIN   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_POS_ENTRY  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_KIN_ENTRY  = 5'd11;
   localparam logic [STEP_W-1:0] STEP_NONE       = 5'd0;

   typedef enum logic [1:0] {
      MODE_FULL    = 2'd0,
      MODE_VEL     = 2'd1,
      MODE_POS     = 2'd2,
      MODE_KINETIC = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE       = 3'd0,
      REG_DT_VEL     = 3'd1,
      REG_DT_POS     = 3'd2,
      REG_INV_MASS_0 = 3'd3,
      REG_INV_MASS_1 = 3'd4,
      REG_INV_MASS_2 = 3'd5,
      REG_INV_MASS_3 = 3'd6
   } reg_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_VEL,
      MUL_POS,
      MUL_MASS,
      MUL_SQ,
      MUL_QLO,
      MUL_QHI
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_MOM,
      WB_D,
      WB_POS,
      WB_SQ_LOAD,
      WB_SQ_ADD,
      WB_E_LO,
      WB_E_HI,
      WB_ACC
   } wb_sel_type;

   typedef enum logic [1:0] {
      FIN_NEVER,
      FIN_ALWAYS,
      FIN_IF_VEL_ONLY
   } fin_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      mul_sel_type       mul;
      axis_type          mul_axis;
      wb_sel_type        wb;
      axis_type          wb_axis;
      fin_type           fin;
      logic              jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] mom_x;
      logic signed [31:0] mom_y;
      logic signed [31:0] mom_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [1:0]         species;
      logic               last_atom;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] new_mom_x;
      logic signed [31:0] new_mom_y;
      logic signed [31:0] new_mom_z;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic [62:0]        kinetic_sum;
      logic [23:0]        atoms_counted;
      logic               is_last;
   } rsp_payload_type;

   function automatic ctrl_word_type make_cw(input mul_sel_type       mul,
                                             input axis_type          mul_axis,
                                             input wb_sel_type        wb,
                                             input axis_type          wb_axis,
                                             input fin_type           fin,
                                             input logic              jump,
                                             input logic [STEP_W-1:0] target);
      ctrl_word_type w;
      w.mul      = mul;
      w.mul_axis = mul_axis;
      w.wb       = wb;
      w.wb_axis  = wb_axis;
      w.fin      = fin;
      w.jump     = jump;
      w.target   = target;
      return w;
   endfunction

   // microprogram; a product lands in the product register one step after issue
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         // momentum kick, then drift
         5'd0:  w = make_cw(MUL_VEL,  AXIS_X, WB_NONE,    AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd1:  w = make_cw(MUL_VEL,  AXIS_Y, WB_MOM,     AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd2:  w = make_cw(MUL_VEL,  AXIS_Z, WB_MOM,     AXIS_Y, FIN_NEVER, 1'b0, STEP_NONE);
         5'd3:  w = make_cw(MUL_POS,  AXIS_X, WB_MOM,     AXIS_Z, FIN_IF_VEL_ONLY, 1'b0,
                            STEP_NONE);
         5'd4:  w = make_cw(MUL_POS,  AXIS_Y, WB_D,       AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd5:  w = make_cw(MUL_MASS, AXIS_X, WB_D,       AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd6:  w = make_cw(MUL_POS,  AXIS_Z, WB_POS,     AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd7:  w = make_cw(MUL_MASS, AXIS_X, WB_D,       AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd8:  w = make_cw(MUL_MASS, AXIS_X, WB_POS,     AXIS_Y, FIN_NEVER, 1'b0, STEP_NONE);
         5'd9:  w = make_cw(MUL_NONE, AXIS_X, WB_POS,     AXIS_Z, FIN_ALWAYS, 1'b0, STEP_NONE);
         // drift only: first product, then join the drift sequence
         5'd10: w = make_cw(MUL_POS,  AXIS_X, WB_NONE,    AXIS_X, FIN_NEVER, 1'b1,
                            STEP_POS_JOIN);
         // kinetic energy
         5'd11: w = make_cw(MUL_SQ,   AXIS_X, WB_NONE,    AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd12: w = make_cw(MUL_SQ,   AXIS_Y, WB_SQ_LOAD, AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd13: w = make_cw(MUL_SQ,   AXIS_Z, WB_SQ_ADD,  AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd14: w = make_cw(MUL_NONE, AXIS_X, WB_SQ_ADD,  AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd15: w = make_cw(MUL_QLO,  AXIS_X, WB_NONE,    AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd16: w = make_cw(MUL_QHI,  AXIS_X, WB_E_LO,    AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd17: w = make_cw(MUL_NONE, AXIS_X, WB_E_HI,    AXIS_X, FIN_NEVER, 1'b0, STEP_NONE);
         5'd18: w = make_cw(MUL_NONE, AXIS_X, WB_ACC,     AXIS_X, FIN_ALWAYS, 1'b0, STEP_NONE);
         default: w = make_cw(MUL_NONE, AXIS_X, WB_NONE,  AXIS_X, FIN_ALWAYS, 1'b0, STEP_NONE);
      endcase
      return w;
   endfunction

   function automatic logic signed [65:0] sext66(input logic [31:0] v);
      return {{34{v[31]}}, v};
   endfunction

   function automatic logic [31:0] sat32(input logic signed [65:0] x);
      logic [31:0] r;
      if (x > SAT_HI) begin
         r = 32'h7fff_ffff;
      end else if (x < SAT_LO) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sel_axis(input logic [2:0][31:0] v, input axis_type a);
      logic [31:0] r;
      case (a)
         AXIS_X:  r = v[0];
         AXIS_Y:  r = v[1];
         AXIS_Z:  r = v[2];
         default: r = v[0];
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/lai_channel_if.sv]
// ============================================================================
// lai channel interfaces
// Valid/ready request and response channels carrying the atom payloads.
// ============================================================================
interface lai_req_if;
   logic                     valid;
   logic                     ready;
   lai_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lai_rsp_if;
   logic                     valid;
   logic                     ready;
   lai_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/leapfrog_atom_integrator.sv]
// ============================================================================
// leapfrog_atom_integrator - microcoded leapfrog step for one atom per request
// Momentum kick, position drift and kinetic energy sum in signed Q16.16.
// ============================================================================
// One request carries one atom and yields one response. A request is taken
// while the sequencer is idle; its microprogram then runs steps 0 to 9 in
// mode 0 (kick and drift), 0 to 3 in mode 1 (kick), 10 and then 4 to 9 in
// mode 2 (drift) and 11 to 18 in mode 3 (kinetic energy), and the next
// request is taken in the cycle after the program ends. Every product goes
// through the single shared 33x33 multiplier in turn, at most one per cycle
// while the program advances, with its result registered before use. The
// response sits in an output register, so a new request may start while the
// previous response waits; a program only stalls on its final step if that
// register is still full and not being read. Configuration registers sit at
// byte offset 4*index (mode, dt_vel, dt_pos, inv_mass_0..3) and may only be
// written while no request is in flight. The kinetic sum and atom count run
// across mode 3 requests and clear after any request marked last_atom.
// ============================================================================
module leapfrog_atom_integrator (
   input  logic              clock,
   input  logic              reset,
   lai_req_if.sink           req_ch,
   lai_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // configuration registers
   lai_pkg::mode_type mode_ff;
   logic [31:0]       dt_vel_ff;
   logic [31:0]       dt_pos_ff;
   logic [31:0]       inv_mass_ff [lai_pkg::NUM_SPECIES];

   // sequencer
   lai_pkg::seq_state_type     seq_state_ff, seq_state_in;
   logic [lai_pkg::STEP_W-1:0] step_ff, step_in;
   lai_pkg::ctrl_word_type     cw;
   logic                       run;
   logic                       fin_now;
   logic                       stall;
   logic                       advance;
   logic                       fin_go;
   logic                       accept;
   logic                       csr_write;
   logic [lai_pkg::STEP_W-1:0] entry_step;

   // per-atom working registers
   logic [2:0][31:0] force_ff;
   logic [2:0][31:0] mom_ff, mom_in;
   logic [2:0][31:0] pos_ff, pos_in;
   logic [31:0]      mass_ff;
   logic             last_ff;
   logic [31:0]      d_ff, d_in;
   logic [63:0]      sq_ff, sq_in;
   logic [63:0]      e_ff, e_in;

   // running totals
   logic [62:0] energy_ff, energy_in;
   logic [23:0] tally_ff, tally_in;

   // multiplier
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_in, prod_ff;
   logic [31:0]        force_sel;
   logic [31:0]        mom_sel;
   logic [31:0]        mom_abs;
   logic [31:0]        mass_sel;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   lai_pkg::rsp_payload_type rsp_data_ff;

   // write-back intermediates
   logic signed [65:0] prod_shr;
   logic [62:0]        e_clamp;
   logic [63:0]        e_total;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign accept        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.data   = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lai_pkg::MODE_FULL;
         dt_vel_ff <= '0;
         dt_pos_ff <= '0;
         for (int i = 0; i < lai_pkg::NUM_SPECIES; i++) begin
            inv_mass_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            lai_pkg::REG_MODE:       mode_ff        <= lai_pkg::mode_type'(csr_pwdata[1:0]);
            lai_pkg::REG_DT_VEL:     dt_vel_ff      <= csr_pwdata;
            lai_pkg::REG_DT_POS:     dt_pos_ff      <= csr_pwdata;
            lai_pkg::REG_INV_MASS_0: inv_mass_ff[0] <= csr_pwdata;
            lai_pkg::REG_INV_MASS_1: inv_mass_ff[1] <= csr_pwdata;
            lai_pkg::REG_INV_MASS_2: inv_mass_ff[2] <= csr_pwdata;
            lai_pkg::REG_INV_MASS_3: inv_mass_ff[3] <= csr_pwdata;
            default: ;  // unmapped offsets are dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         lai_pkg::REG_MODE:       csr_prdata = {30'd0, mode_ff};
         lai_pkg::REG_DT_VEL:     csr_prdata = dt_vel_ff;
         lai_pkg::REG_DT_POS:     csr_prdata = dt_pos_ff;
         lai_pkg::REG_INV_MASS_0: csr_prdata = inv_mass_ff[0];
         lai_pkg::REG_INV_MASS_1: csr_prdata = inv_mass_ff[1];
         lai_pkg::REG_INV_MASS_2: csr_prdata = inv_mass_ff[2];
         lai_pkg::REG_INV_MASS_3: csr_prdata = inv_mass_ff[3];
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // sequencer control
   // ---------------------------------------------------------------------------
   assign cw  = lai_pkg::ucode_rom(step_ff);
   assign run = (seq_state_ff == lai_pkg::SEQ_RUN);

   // velocity-only mode leaves the program once the z momentum is written
   assign fin_now = (cw.fin == lai_pkg::FIN_ALWAYS) ||
                    ((cw.fin == lai_pkg::FIN_IF_VEL_ONLY) &&
                     (mode_ff == lai_pkg::MODE_VEL));

   // hold the last step while the previous response is still unread
   assign stall   = run && fin_now && rsp_valid_ff && !rsp_ch.ready;
   assign advance = run && !stall;
   assign fin_go  = advance && fin_now;

   always_comb begin
      case (mode_ff)
         lai_pkg::MODE_POS:     entry_step = lai_pkg::STEP_POS_ENTRY;
         lai_pkg::MODE_KINETIC: entry_step = lai_pkg::STEP_KIN_ENTRY;
         default:               entry_step = lai_pkg::STEP_FULL_ENTRY;
      endcase
   end

   // next state
   always_comb begin
      seq_state_in = seq_state_ff;
      case (seq_state_ff)
         lai_pkg::SEQ_IDLE: if (req_ch.valid) begin
            seq_state_in = lai_pkg::SEQ_RUN;
         end
         lai_pkg::SEQ_RUN: if (fin_go) begin
            seq_state_in = lai_pkg::SEQ_IDLE;
         end
         default: seq_state_in = lai_pkg::SEQ_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready = 1'b0;
      case (seq_state_ff)
         lai_pkg::SEQ_IDLE: req_ch.ready = 1'b1;
         lai_pkg::SEQ_RUN:  req_ch.ready = 1'b0;
         default:           req_ch.ready = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (accept) begin
         step_in = entry_step;
      end else if (advance) begin
         step_in = cw.jump ? cw.target : step_ff + lai_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= lai_pkg::SEQ_IDLE;
         step_ff      <= lai_pkg::STEP_FULL_ENTRY;
      end else begin
         seq_state_ff <= seq_state_in;
         step_ff      <= step_in;
      end
   end

   // ---------------------------------------------------------------------------
   // shared multiplier, at most one product per step
   // ---------------------------------------------------------------------------
   assign force_sel = lai_pkg::sel_axis(force_ff, cw.mul_axis);
   assign mom_sel   = lai_pkg::sel_axis(mom_ff, cw.mul_axis);
   assign mom_abs   = mom_sel[31] ? (~mom_sel + 32'd1) : mom_sel;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cw.mul)
         lai_pkg::MUL_VEL: begin
            op_a = $signed({1'b0, dt_vel_ff});
            op_b = $signed({force_sel[31], force_sel});
         end
         lai_pkg::MUL_POS: begin
            op_a = $signed({1'b0, dt_pos_ff});
            op_b = $signed({mom_sel[31], mom_sel});
         end
         lai_pkg::MUL_MASS: begin
            op_a = $signed({d_ff[31], d_ff});
            op_b = $signed({1'b0, mass_ff});
         end
         lai_pkg::MUL_SQ: begin
            op_a = $signed({1'b0, mom_abs});
            op_b = $signed({1'b0, mom_abs});
         end
         // q = sq >> 16 split into a low word and a high half word
         lai_pkg::MUL_QLO: begin
            op_a = $signed({1'b0, sq_ff[47:16]});
            op_b = $signed({1'b0, mass_ff});
         end
         lai_pkg::MUL_QHI: begin
            op_a = $signed({17'd0, sq_ff[63:48]});
            op_b = $signed({1'b0, mass_ff});
         end
         default: ;
      endcase
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (advance && (cw.mul != lai_pkg::MUL_NONE)) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------------------
   // write-back of the product from the previous step
   // ---------------------------------------------------------------------------
   assign prod_shr = prod_ff >>> 16;
   assign e_clamp  = e_ff[63] ? lai_pkg::MASK63 : e_ff[62:0];
   assign e_total  = {1'b0, energy_ff} + {1'b0, e_clamp};

   always_comb begin
      mom_in    = mom_ff;
      pos_in    = pos_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      e_in      = e_ff;
      energy_in = energy_ff;
      tally_in  = tally_ff;
      if (advance) begin
         case (cw.wb)
            // p' = sat(p + (dt_vel*f >> 16))
            lai_pkg::WB_MOM: begin
               case (cw.wb_axis)
                  lai_pkg::AXIS_X: mom_in[0] = lai_pkg::sat32(
                                      lai_pkg::sext66(mom_ff[0]) + prod_shr);
                  lai_pkg::AXIS_Y: mom_in[1] = lai_pkg::sat32(
                                      lai_pkg::sext66(mom_ff[1]) + prod_shr);
                  lai_pkg::AXIS_Z: mom_in[2] = lai_pkg::sat32(
                                      lai_pkg::sext66(mom_ff[2]) + prod_shr);
                  default: ;
               endcase
            end
            // displacement before the mass scale
            lai_pkg::WB_D: d_in = lai_pkg::sat32(prod_shr);
            // r' = sat(r + (d*m >> 16))
            lai_pkg::WB_POS: begin
               case (cw.wb_axis)
                  lai_pkg::AXIS_X: pos_in[0] = lai_pkg::sat32(
                                      lai_pkg::sext66(pos_ff[0]) + prod_shr);
                  lai_pkg::AXIS_Y: pos_in[1] = lai_pkg::sat32(
                                      lai_pkg::sext66(pos_ff[1]) + prod_shr);
                  lai_pkg::AXIS_Z: pos_in[2] = lai_pkg::sat32(
                                      lai_pkg::sext66(pos_ff[2]) + prod_shr);
                  default: ;
               endcase
            end
            lai_pkg::WB_SQ_LOAD: sq_in = prod_ff[63:0];
            lai_pkg::WB_SQ_ADD:  sq_in = sq_ff + prod_ff[63:0];
            // low word of q times mass, the half factor folded into the shift
            lai_pkg::WB_E_LO:    e_in  = 64'(prod_ff[63:17]);
            lai_pkg::WB_E_HI:    e_in  = e_ff + {prod_ff[48:0], 15'd0};
            lai_pkg::WB_ACC: begin
               energy_in = e_total[63] ? lai_pkg::MASK63 : e_total[62:0];
               tally_in  = (tally_ff == lai_pkg::MASK24) ? tally_ff
                                                         : tally_ff + 24'd1;
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // working registers
   // ---------------------------------------------------------------------------
   assign mass_sel = (int'(req_ch.data.species) < lai_pkg::NUM_SPECIES) ?
                     inv_mass_ff[req_ch.data.species] : 32'd0;

   always_ff @(posedge clock) begin
      if (accept) begin
         force_ff <= {req_ch.data.force_z, req_ch.data.force_y, req_ch.data.force_x};
         mom_ff   <= {req_ch.data.mom_z, req_ch.data.mom_y, req_ch.data.mom_x};
         pos_ff   <= {req_ch.data.pos_z, req_ch.data.pos_y, req_ch.data.pos_x};
         mass_ff  <= mass_sel;
         last_ff  <= req_ch.data.last_atom;
      end else begin
         mom_ff <= mom_in;
         pos_ff <= pos_in;
      end
      d_ff  <= d_in;
      sq_ff <= sq_in;
      e_ff  <= e_in;
   end

   // totals clear after a last atom has been reported
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= '0;
         tally_ff  <= '0;
      end else if (fin_go && last_ff) begin
         energy_ff <= '0;
         tally_ff  <= '0;
      end else begin
         energy_ff <= energy_in;
         tally_ff  <= tally_in;
      end
   end

   // ---------------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_data_ff.new_mom_x     <= mom_in[0];
         rsp_data_ff.new_mom_y     <= mom_in[1];
         rsp_data_ff.new_mom_z     <= mom_in[2];
         rsp_data_ff.new_pos_x     <= pos_in[0];
         rsp_data_ff.new_pos_y     <= pos_in[1];
         rsp_data_ff.new_pos_z     <= pos_in[2];
         rsp_data_ff.kinetic_sum   <= energy_in;
         rsp_data_ff.atoms_counted <= tally_in;
         rsp_data_ff.is_last       <= last_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (seq_state_ff == lai_pkg::SEQ_RUN))
      else $error("accepted request did not start the program");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> ($stable(step_ff) && $stable(energy_ff) && $stable(tally_ff)
                 && $stable(sq_ff)))
      else $error("stalled final step changed sequencer or totals");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> (rsp_valid_ff && (seq_state_ff == lai_pkg::SEQ_IDLE)))
      else $error("finished program did not post a response");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (fin_go && last_ff) |=> ((energy_ff == '0) && (tally_ff == '0)))
      else $error("totals not cleared after last atom");

endmodule

[tb/leapfrog_atom_integrator_tb.sv]
// ============================================================================
// leapfrog_atom_integrator_tb - self-checking bench for the atom integrator
// Drives atoms with random gaps, stalls the response side at random and checks
// every response against a fixed-point model of kick, drift and kinetic energy.
// ============================================================================
module leapfrog_atom_integrator_tb;

   // register index that the block does not decode
   localparam logic [2:0] REG_UNUSED = 3'd7;
   // cycles without any handshake or register access before the run is abandoned
   localparam int STALL_LIMIT = 5000;
   // settle time after the last response
   localparam int DRAIN_CYCLES = 30;

   logic clock = 1'b0;
   logic reset;

   lai_req_if req_ch ();
   lai_rsp_if rsp_ch ();

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   leapfrog_atom_integrator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the register file, updated as each write lands
   lai_pkg::mode_type cfg_mode = lai_pkg::MODE_FULL;
   logic [31:0] cfg_dt_vel = '0;
   logic [31:0] cfg_dt_pos = '0;
   logic [31:0] cfg_inv_mass [lai_pkg::NUM_SPECIES] = '{default: '0};

   // running kinetic totals as the block should hold them
   logic [62:0] energy_total = '0;
   logic [23:0] atom_total = '0;

   lai_pkg::req_payload_type atom_backlog [$];       // atoms waiting to be driven
   lai_pkg::rsp_payload_type predicted_updates [$];  // responses owed by the block

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   logic quiet = 1'b0;   // no gaps and no stalls while set

   // -------------------------------------------------------------------------
   // fixed-point model
   // -------------------------------------------------------------------------
   function automatic logic signed [31:0] sat_q16(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic lai_pkg::rsp_payload_type integrate_atom(
      input lai_pkg::req_payload_type a);
      lai_pkg::rsp_payload_type o;
      logic signed [31:0] frc [3];
      logic signed [31:0] mom [3];
      logic signed [31:0] pos [3];
      logic signed [31:0] d;
      logic [31:0]        inv;
      logic [31:0]        mag;
      logic [63:0]        sq;
      logic [63:0]        q;
      logic [63:0]        e;
      logic [63:0]        sum;
      logic [127:0]       wide;
      int                 k;

      frc = '{a.force_x, a.force_y, a.force_z};
      mom = '{a.mom_x, a.mom_y, a.mom_z};
      pos = '{a.pos_x, a.pos_y, a.pos_z};
      // species past the configured count see zero inverse mass
      inv = (a.species < lai_pkg::NUM_SPECIES) ? cfg_inv_mass[a.species] : '0;

      // kick: p += dt_vel * f, product floored by the arithmetic shift
      if (cfg_mode == lai_pkg::MODE_FULL || cfg_mode == lai_pkg::MODE_VEL) begin
         for (k = 0; k < 3; k++) begin
            mom[k] = sat_q16(longint'(mom[k]) +
                             ((longint'({32'b0, cfg_dt_vel}) * longint'(frc[k])) >>> 16));
         end
      end

      // drift uses the kicked momentum in full mode, the input one otherwise
      if (cfg_mode == lai_pkg::MODE_FULL || cfg_mode == lai_pkg::MODE_POS) begin
         for (k = 0; k < 3; k++) begin
            d = sat_q16((longint'({32'b0, cfg_dt_pos}) * longint'(mom[k])) >>> 16);
            pos[k] = sat_q16(longint'(pos[k]) +
                             ((longint'(d) * longint'({32'b0, inv})) >>> 16));
         end
      end

      // kinetic: e = (|p|^2 >> 16) * inv_mass >> 17, both totals saturate
      if (cfg_mode == lai_pkg::MODE_KINETIC) begin
         sq = '0;
         for (k = 0; k < 3; k++) begin
            mag = mom[k][31] ? (~mom[k] + 32'd1) : mom[k];
            sq  = sq + {32'b0, mag} * {32'b0, mag};
         end
         q    = sq >> 16;
         wide = {64'b0, q} * {96'b0, inv};
         e    = wide[80:17];
         if (e > {1'b0, lai_pkg::MASK63}) e = {1'b0, lai_pkg::MASK63};
         sum = {1'b0, energy_total} + e;
         energy_total = (sum > {1'b0, lai_pkg::MASK63}) ? lai_pkg::MASK63 : sum[62:0];
         if (atom_total != lai_pkg::MASK24) atom_total = atom_total + 24'd1;
      end

      o.new_mom_x     = mom[0];
      o.new_mom_y     = mom[1];
      o.new_mom_z     = mom[2];
      o.new_pos_x     = pos[0];
      o.new_pos_y     = pos[1];
      o.new_pos_z     = pos[2];
      o.kinetic_sum   = energy_total;
      o.atoms_counted = atom_total;
      o.is_last       = a.last_atom;

      // a last atom reports its totals, then a new pass starts from zero
      if (a.last_atom) begin
         energy_total = '0;
         atom_total   = '0;
      end
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // random values
   // -------------------------------------------------------------------------
   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // signed q16.16 with weight on the rails and on small magnitudes
   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         4, 5:    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // unsigned q16.16 step or inverse mass
   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h0001_0000;   // one
         3:       return 32'h0000_8000;   // one half
         4, 5:    return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   // y carries the complement of x, z is random
   task automatic queue_atom(input logic [31:0] f, input logic [31:0] p,
                             input logic [31:0] r, input logic [1:0] sp,
                             input logic last);
      lai_pkg::req_payload_type a;
      a.force_x   = f;
      a.force_y   = ~f;
      a.force_z   = pick_q16();
      a.mom_x     = p;
      a.mom_y     = ~p;
      a.mom_z     = pick_q16();
      a.pos_x     = r;
      a.pos_y     = ~r;
      a.pos_z     = pick_q16();
      a.species   = sp;
      a.last_atom = last;
      atom_backlog.push_back(a);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         lai_pkg::REG_MODE:       cfg_mode = lai_pkg::mode_type'(value[1:0]);
         lai_pkg::REG_DT_VEL:     cfg_dt_vel = value;
         lai_pkg::REG_DT_POS:     cfg_dt_pos = value;
         lai_pkg::REG_INV_MASS_0: cfg_inv_mass[0] = value;
         lai_pkg::REG_INV_MASS_1: cfg_inv_mass[1] = value;
         lai_pkg::REG_INV_MASS_2: cfg_inv_mass[2] = value;
         lai_pkg::REG_INV_MASS_3: cfg_inv_mass[3] = value;
         default: ;   // undecoded index, no effect
      endcase
   endtask

   // block is idle once every atom is taken and every response is back
   task automatic wait_idle();
      do @(negedge clock);
      while (atom_backlog.size() != 0 || req_ch.valid || predicted_updates.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // request driver
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      logic holding;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         holding = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            predicted_updates.push_back(integrate_atom(req_ch.data));
            holding = 1'b0;
         end
         if (!holding) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (atom_backlog.size() != 0) begin
               req_ch.data  <= atom_backlog.pop_front();
               req_ch.valid <= 1'b1;
               req_gap = (quiet || $urandom_range(0, 1)) ? 0 : pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // response monitor and checker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      lai_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_updates.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = predicted_updates.pop_front();
               check_field("new_mom_x", want.new_mom_x, rsp_ch.data.new_mom_x);
               check_field("new_mom_y", want.new_mom_y, rsp_ch.data.new_mom_y);
               check_field("new_mom_z", want.new_mom_z, rsp_ch.data.new_mom_z);
               check_field("new_pos_x", want.new_pos_x, rsp_ch.data.new_pos_x);
               check_field("new_pos_y", want.new_pos_y, rsp_ch.data.new_pos_y);
               check_field("new_pos_z", want.new_pos_z, rsp_ch.data.new_pos_z);
               check_field("kinetic_sum", want.kinetic_sum, rsp_ch.data.kinetic_sum);
               check_field("atoms_counted", want.atoms_counted, rsp_ch.data.atoms_counted);
               check_field("is_last", want.is_last, rsp_ch.data.is_last);
            end
         end
         // back-pressure: random stalls of mixed length
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall = pick_gap() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: any handshake or register access counts as progress
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      int pass_left;
      logic last;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset registers: zero steps, so every atom passes through untouched
      queue_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 2'd3, 1'b0);
      queue_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2'd0, 1'b0);
      wait_idle();

      // full steps, one inverse mass per species including zero
      write_csr(lai_pkg::REG_DT_VEL, 32'hffff_ffff);
      write_csr(lai_pkg::REG_DT_POS, 32'hffff_ffff);
      write_csr(lai_pkg::REG_INV_MASS_0, 32'hffff_ffff);
      write_csr(lai_pkg::REG_INV_MASS_1, 32'h0001_0000);
      write_csr(lai_pkg::REG_INV_MASS_2, 32'h0000_8000);
      write_csr(lai_pkg::REG_INV_MASS_3, 32'h0000_0000);
      // kick and drift into both rails
      queue_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 2'd0, 1'b0);
      queue_atom(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 2'd1, 1'b0);
      queue_atom(32'hffff_ffff, 32'h0001_0000, 32'h8000_0000, 2'd2, 1'b0);
      queue_atom(32'h0000_4000, 32'h0000_0000, 32'h1234_5678, 2'd3, 1'b0);
      wait_idle();

      write_csr(lai_pkg::REG_MODE, 32'(lai_pkg::MODE_VEL));
      queue_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 2'd0, 1'b0);
      queue_atom(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 2'd2, 1'b1);
      wait_idle();

      write_csr(lai_pkg::REG_MODE, 32'(lai_pkg::MODE_POS));
      queue_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 2'd0, 1'b0);
      queue_atom(32'h0000_0000, 32'h0000_8000, 32'hffff_0000, 2'd3, 1'b0);
      wait_idle();

      // kinetic pass with rail momenta drives the energy sum into saturation
      write_csr(lai_pkg::REG_MODE, 32'(lai_pkg::MODE_KINETIC));
      queue_atom(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 2'd0, 1'b0);
      queue_atom(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 2'd0, 1'b0);
      queue_atom(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 2'd0, 1'b0);
      queue_atom(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 2'd0, 1'b1);
      // zero inverse mass counts the atom but adds no energy
      queue_atom(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 2'd3, 1'b0);
      queue_atom(32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 2'd1, 1'b0);
      wait_idle();

      // totals survive a mode change and an undecoded write, then a last
      // atom outside kinetic mode reports and clears them
      write_csr(REG_UNUSED, 32'hdead_beef);
      write_csr(lai_pkg::REG_MODE, 32'(lai_pkg::MODE_FULL));
      queue_atom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 2'd1, 1'b1);
      queue_atom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 2'd1, 1'b0);
      wait_idle();

      // random part: each phase a new register setting, atoms grouped in
      // passes closed by a last atom, with an occasional stray last
      for (int ph = 0; ph < 16; ph++) begin
         quiet = (ph % 5 == 4);
         write_csr(lai_pkg::REG_MODE, 32'(lai_pkg::mode_type'(ph % 4)));
         write_csr(lai_pkg::REG_DT_VEL, pick_step());
         write_csr(lai_pkg::REG_DT_POS, pick_step());
         write_csr(lai_pkg::REG_INV_MASS_0, pick_step());
         write_csr(lai_pkg::REG_INV_MASS_1, pick_step());
         write_csr(lai_pkg::REG_INV_MASS_2, pick_step());
         write_csr(lai_pkg::REG_INV_MASS_3, pick_step());
         pass_left = $urandom_range(1, 20);
         for (int n = 0; n < 50; n++) begin
            last = (pass_left == 1) || ($urandom_range(0, 19) == 0);
            pass_left--;
            if (last) pass_left = $urandom_range(1, 20);
            queue_atom(pick_q16(), pick_q16(), pick_q16(), 2'($urandom_range(0, 3)), last);
         end
         wait_idle();
      end

      quiet = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
